FILE: hdl/rtp_pkg.sv
package rtp_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int ITERATIONS = 16;
    localparam int SQRT_STEPS = DATA_WIDTH;
    localparam int NUM_CELLS  = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;
    localparam int IDX_W      = $clog2(NUM_CELLS);
    localparam int NUM_STAGES = NUM_CELLS + 3;

    localparam int CW      = 64;
    localparam int ZW      = 32;
    localparam int SW      = 2 * DATA_WIDTH + 1;
    localparam int SQ_W    = 2 * DATA_WIDTH;
    localparam int SCALE   = 61 - DATA_WIDTH;
    localparam int MAG_W   = 16;
    localparam int PHASE_W = 17;

    localparam int PHASE_SHIFT = 16;
    localparam int ROUND_HALF  = 1 << (PHASE_SHIFT - 1);

    localparam logic [SW-1:0] SQRT_TOP_BIT = SW'(1) << (2 * (SQRT_STEPS - 1));

    localparam logic signed [PHASE_W-1:0] HALF_PI_UNITS = PHASE_W'(16384);
    localparam logic signed [PHASE_W-1:0] PI_UNITS      = PHASE_W'(32768);

    localparam int ATAN_IDX_W = 5;

    localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 2, 1, 0, 0
    };

    typedef struct packed {
        logic re_zero;
        logic im_zero;
        logic re_neg;
        logic im_neg;
    } t_flags;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [SW-1:0]        rem;
        logic [SW-1:0]        root;
        t_flags               flags;
    } t_cell_data;

endpackage

FILE: hdl/rectangular_to_polar.sv
// Channel  | Valid    | Ready    | Payload
// input    | i_valid  | o_ready  | i_real_part, i_imag_part
// output   | o_valid  | i_ready  | o_magnitude, o_phase
//
// One sample per cycle while the output is not stalled; NUM_STAGES (19) stages: two prep stages
// (squares, then their sum), one cell per CORDIC and square-root step, one output stage.
// Every stage has its own valid bit and loads when it is empty or its
// neighbor downstream loads, so bubbles close up while the output is stalled.
// Reset clears all valid bits; payload registers are not reset.
module rectangular_to_polar (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [rtp_pkg::DATA_WIDTH-1:0] i_real_part,
    input  logic signed [rtp_pkg::DATA_WIDTH-1:0] i_imag_part,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [rtp_pkg::MAG_W-1:0]             o_magnitude,
    output logic signed [rtp_pkg::PHASE_W-1:0]    o_phase
);

    logic [rtp_pkg::NUM_STAGES-1:0]  r_vld;
    logic [rtp_pkg::NUM_STAGES:0]    stage_en;
    rtp_pkg::t_cell_data             cell_d [rtp_pkg::NUM_CELLS+1];
    rtp_pkg::t_cell_data             last_d;

    logic signed [rtp_pkg::ZW:0]           z_round;
    logic signed [rtp_pkg::PHASE_W-1:0]    cordic_ph;
    logic [rtp_pkg::MAG_W-1:0]             n_magnitude;
    logic signed [rtp_pkg::PHASE_W-1:0]    n_phase;
    logic [rtp_pkg::MAG_W-1:0]             r_magnitude;
    logic signed [rtp_pkg::PHASE_W-1:0]    r_phase;

    always_comb begin
        stage_en[rtp_pkg::NUM_STAGES] = i_ready;
        for (int k = rtp_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_ready = stage_en[0];
    assign o_valid = r_vld[rtp_pkg::NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < rtp_pkg::NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    rtp_prep u_prep (
        .i_clk       (i_clk),
        .i_en_a      (stage_en[0]),
        .i_en_b      (stage_en[1]),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .o_data      (cell_d[0])
    );

    for (genvar k = 0; k < rtp_pkg::NUM_CELLS; k++) begin : g_cell
        rtp_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (stage_en[k+2]),
            .i_index (rtp_pkg::IDX_W'(k)),
            .i_data  (cell_d[k]),
            .o_data  (cell_d[k+1])
        );
    end

    assign last_d = cell_d[rtp_pkg::NUM_CELLS];

    always_comb begin
        n_magnitude = last_d.root[rtp_pkg::MAG_W-1:0]
                    + rtp_pkg::MAG_W'(last_d.rem > last_d.root);
        z_round   = {last_d.z[rtp_pkg::ZW-1], last_d.z}
                  + (rtp_pkg::ZW+1)'(rtp_pkg::ROUND_HALF);
        cordic_ph = z_round[rtp_pkg::PHASE_SHIFT +: rtp_pkg::PHASE_W];
        priority if (last_d.flags.re_zero) begin
            n_phase = last_d.flags.im_neg ? -rtp_pkg::HALF_PI_UNITS : rtp_pkg::HALF_PI_UNITS;
        end else if (last_d.flags.im_zero) begin
            n_phase = last_d.flags.re_neg ? rtp_pkg::PI_UNITS : '0;
        end else if (last_d.flags.re_neg) begin
            n_phase = cordic_ph + rtp_pkg::PI_UNITS;
        end else begin
            n_phase = cordic_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[rtp_pkg::NUM_STAGES-1]) begin
            r_magnitude <= n_magnitude;
            r_phase     <= n_phase;
        end
    end

    assign o_magnitude = r_magnitude;
    assign o_phase     = r_phase;

endmodule

FILE: hdl/rtp_prep.sv
module rtp_prep (
    input  logic                                   i_clk,
    input  logic                                   i_en_a,
    input  logic                                   i_en_b,
    input  logic signed [rtp_pkg::DATA_WIDTH-1:0]  i_real_part,
    input  logic signed [rtp_pkg::DATA_WIDTH-1:0]  i_imag_part,
    output rtp_pkg::t_cell_data                    o_data
);

    logic [rtp_pkg::DATA_WIDTH-1:0]  abs_re;
    logic [rtp_pkg::DATA_WIDTH-1:0]  abs_im;
    logic signed [rtp_pkg::CW-1:0]   im_ext;
    logic signed [rtp_pkg::CW-1:0]   n_x;
    logic signed [rtp_pkg::CW-1:0]   n_y;
    logic [rtp_pkg::SQ_W-1:0]        n_sq_re;
    logic [rtp_pkg::SQ_W-1:0]        n_sq_im;
    rtp_pkg::t_flags                 n_flags;

    logic [rtp_pkg::SQ_W-1:0]        r_sq_re;
    logic [rtp_pkg::SQ_W-1:0]        r_sq_im;
    logic signed [rtp_pkg::CW-1:0]   r_x;
    logic signed [rtp_pkg::CW-1:0]   r_y;
    rtp_pkg::t_flags                 r_flags;
    rtp_pkg::t_cell_data             n_data;
    rtp_pkg::t_cell_data             r_data;

    always_comb begin
        n_flags.re_zero = (i_real_part == '0);
        n_flags.im_zero = (i_imag_part == '0);
        n_flags.re_neg  = i_real_part[rtp_pkg::DATA_WIDTH-1];
        n_flags.im_neg  = i_imag_part[rtp_pkg::DATA_WIDTH-1];
        abs_re = n_flags.re_neg ? (~i_real_part + 1'b1) : i_real_part;
        abs_im = n_flags.im_neg ? (~i_imag_part + 1'b1) : i_imag_part;
        n_sq_re = rtp_pkg::SQ_W'(abs_re) * rtp_pkg::SQ_W'(abs_re);
        n_sq_im = rtp_pkg::SQ_W'(abs_im) * rtp_pkg::SQ_W'(abs_im);
        im_ext = {{(rtp_pkg::CW - rtp_pkg::DATA_WIDTH){i_imag_part[rtp_pkg::DATA_WIDTH-1]}},
                  i_imag_part};
        n_x = rtp_pkg::CW'(abs_re) << rtp_pkg::SCALE;
        n_y = (n_flags.re_neg ? -im_ext : im_ext) <<< rtp_pkg::SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_sq_re <= n_sq_re;
            r_sq_im <= n_sq_im;
            r_x     <= n_x;
            r_y     <= n_y;
            r_flags <= n_flags;
        end
    end

    always_comb begin
        n_data.x     = r_x;
        n_data.y     = r_y;
        n_data.z     = '0;
        n_data.rem   = rtp_pkg::SW'(r_sq_re) + rtp_pkg::SW'(r_sq_im);
        n_data.root  = '0;
        n_data.flags = r_flags;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: hdl/rtp_cell.sv
module rtp_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rtp_pkg::IDX_W-1:0]  i_index,
    input  rtp_pkg::t_cell_data        i_data,
    output rtp_pkg::t_cell_data        o_data
);

    logic signed [rtp_pkg::CW-1:0]  xs;
    logic signed [rtp_pkg::CW-1:0]  ys;
    logic [rtp_pkg::SW-1:0]         sq_bit;
    logic [rtp_pkg::SW-1:0]         trial;
    logic [rtp_pkg::SW:0]           diff;
    rtp_pkg::t_cell_data            n_data;
    rtp_pkg::t_cell_data            r_data;

    always_comb begin
        n_data = i_data;
        xs     = i_data.x >>> i_index;
        ys     = i_data.y >>> i_index;
        sq_bit = rtp_pkg::SQRT_TOP_BIT >> {i_index, 1'b0};
        trial  = i_data.root | sq_bit;
        diff   = {1'b0, i_data.rem} - {1'b0, trial};
        if (int'(i_index) < rtp_pkg::ITERATIONS) begin
            if (i_data.y[rtp_pkg::CW-1]) begin
                n_data.x = i_data.x - ys;
                n_data.y = i_data.y + xs;
                n_data.z = i_data.z - rtp_pkg::ATAN_TAB[rtp_pkg::ATAN_IDX_W'(i_index)];
            end else begin
                n_data.x = i_data.x + ys;
                n_data.y = i_data.y - xs;
                n_data.z = i_data.z + rtp_pkg::ATAN_TAB[rtp_pkg::ATAN_IDX_W'(i_index)];
            end
        end
        if (int'(i_index) < rtp_pkg::SQRT_STEPS) begin
            if (!diff[rtp_pkg::SW]) begin
                n_data.rem  = diff[rtp_pkg::SW-1:0];
                n_data.root = (i_data.root >> 1) | sq_bit;
            end else begin
                n_data.root = i_data.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: hdl/rtp_checker.sv
module rtp_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  o_ready,
    input  logic signed [rtp_pkg::DATA_WIDTH-1:0] i_real_part,
    input  logic signed [rtp_pkg::DATA_WIDTH-1:0] i_imag_part,
    input  logic                                  o_valid,
    input  logic                                  i_ready,
    input  logic [rtp_pkg::MAG_W-1:0]             o_magnitude,
    input  logic signed [rtp_pkg::PHASE_W-1:0]    o_phase
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_magnitude) && $stable(o_phase))
        else $error("output transfer changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while the output stage is empty");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_magnitude <= rtp_pkg::MAG_W'(46341))
        else $error("magnitude out of range");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_phase >= -rtp_pkg::HALF_PI_UNITS)
                 && (o_phase <= rtp_pkg::PI_UNITS + rtp_pkg::HALF_PI_UNITS))
        else $error("phase out of range");

endmodule

bind rectangular_to_polar rtp_checker u_rtp_checker (.*);

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [rtp_pkg::DATA_WIDTH-1:0] t_sample;

    typedef struct packed {
        logic [rtp_pkg::MAG_W-1:0]          mag;
        logic signed [rtp_pkg::PHASE_W-1:0] ph;
    } t_polar;

    typedef struct {
        int re;
        int im;
        bit known;
        int mag;
        int ph;
    } t_sample_row;

    localparam int NUM_DIRECTED = 24;
    localparam int NUM_RANDOM   = 1750;
    localparam int GAP_END      = 1200;

    localparam longint ARCTAN_UNITS [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 2, 1, 0, 0
    };

    t_sample_row directed_rows [NUM_DIRECTED] = '{
        '{0, 0, 1'b1, 0, 16384},
        '{0, -5, 1'b1, 5, -16384},
        '{0, 32767, 1'b1, 32767, 16384},
        '{0, -32768, 1'b1, 32768, -16384},
        '{7, 0, 1'b1, 7, 0},
        '{-7, 0, 1'b1, 7, 32768},
        '{32767, 0, 1'b1, 32767, 0},
        '{-32768, 0, 1'b1, 32768, 32768},
        '{0, 1, 1'b1, 1, 16384},
        '{-1, 0, 1'b1, 1, 32768},
        '{3, 4, 1'b0, 0, 0},
        '{-3, 4, 1'b0, 0, 0},
        '{-3, -4, 1'b0, 0, 0},
        '{3, -4, 1'b0, 0, 0},
        '{1, 1, 1'b0, 0, 0},
        '{-1, -1, 1'b0, 0, 0},
        '{32767, 32767, 1'b0, 0, 0},
        '{-32768, -32768, 1'b0, 0, 0},
        '{32767, -32768, 1'b0, 0, 0},
        '{-32768, 32767, 1'b0, 0, 0},
        '{1, -32768, 1'b0, 0, 0},
        '{-1, 32767, 1'b0, 0, 0},
        '{32767, 1, 1'b0, 0, 0},
        '{-32768, -1, 1'b0, 0, 0}
    };

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_sample i_real_part;
    t_sample i_imag_part;
    logic    o_valid;
    logic    i_ready;
    logic [rtp_pkg::MAG_W-1:0]          o_magnitude;
    logic signed [rtp_pkg::PHASE_W-1:0] o_phase;

    t_polar pending_polar [$];
    int     error_count = 0;
    int     transfers_out = 0;
    int     axis_samples = 0;
    bit     send_gaps = 1'b1;
    bit     recv_gaps = 1'b1;

    rectangular_to_polar dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude),
        .o_phase     (o_phase)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_polar to_polar(input t_sample re, input t_sample im);
        longint          re_l;
        longint          im_l;
        longint unsigned sum_sq;
        longint unsigned root;
        longint unsigned trial;
        longint          x;
        longint          y;
        longint          z;
        longint          x_sh;
        longint          y_sh;
        longint          ph;
        t_polar          res;
        re_l = longint'(re);
        im_l = longint'(im);
        sum_sq = longint'(re_l * re_l) + longint'(im_l * im_l);
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum_sq)
                root = trial;
        end
        if (sum_sq - root * root > root)
            root = root + 1;
        if (re_l == 0) begin
            ph = (im_l < 0) ? -longint'(rtp_pkg::HALF_PI_UNITS)
                            : longint'(rtp_pkg::HALF_PI_UNITS);
        end else if (im_l == 0) begin
            ph = (re_l < 0) ? longint'(rtp_pkg::PI_UNITS) : 0;
        end else begin
            x = ((re_l < 0) ? -re_l : re_l) * (longint'(1) << rtp_pkg::SCALE);
            y = ((re_l < 0) ? -im_l : im_l) * (longint'(1) << rtp_pkg::SCALE);
            z = 0;
            for (int i = 0; i < rtp_pkg::ITERATIONS; i++) begin
                x_sh = x >>> i;
                y_sh = y >>> i;
                if (y < 0) begin
                    x = x - y_sh;
                    y = y + x_sh;
                    z = z - ARCTAN_UNITS[i % 32];
                end else begin
                    x = x + y_sh;
                    y = y - x_sh;
                    z = z + ARCTAN_UNITS[i % 32];
                end
            end
            ph = (z + 32768) >>> 16;
            if (re_l < 0)
                ph = ph + longint'(rtp_pkg::PI_UNITS);
        end
        res.mag = root[rtp_pkg::MAG_W-1:0];
        res.ph  = ph[rtp_pkg::PHASE_W-1:0];
        return res;
    endfunction

    function automatic int pick_extreme();
        int vals [6] = '{-32768, -32767, -1, 0, 1, 32767};
        return vals[$urandom_range(0, 5)];
    endfunction

    task automatic send_sample(input t_sample re, input t_sample im, input bit known,
                               input t_polar typed);
        t_polar want;
        want = known ? typed : to_polar(re, im);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_real_part <= re;
        i_imag_part <= im;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_polar.push_back(want);
        if (re == 0 || im == 0)
            axis_samples++;
        @(negedge i_clk);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_polar want;
        if (i_rst_n && o_valid && i_ready) begin
            transfers_out++;
            if (pending_polar.size() == 0) begin
                $error("unexpected transfer: magnitude %0d phase %0d", o_magnitude, o_phase);
                error_count++;
            end else begin
                want = pending_polar.pop_front();
                if (o_magnitude !== want.mag) begin
                    $error("magnitude: expected %0d, actual %0d", want.mag, o_magnitude);
                    error_count++;
                end
                if (o_phase !== want.ph) begin
                    $error("phase: expected %0d, actual %0d", want.ph, o_phase);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_sample re;
        t_sample im;
        t_polar  typed;
        int      mode;
        int      a;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_real_part = '0;
        i_imag_part = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            typed.mag = directed_rows[k].mag[rtp_pkg::MAG_W-1:0];
            typed.ph  = directed_rows[k].ph[rtp_pkg::PHASE_W-1:0];
            send_sample(t_sample'(directed_rows[k].re), t_sample'(directed_rows[k].im),
                        directed_rows[k].known, typed);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == GAP_END / 2) begin
                i_valid <= 1'b0;
                while (pending_polar.size() != 0)
                    @(negedge i_clk);
                @(negedge i_clk);
            end
            if (n == GAP_END) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            mode = $urandom_range(0, 9);
            case (mode)
                5: begin
                    re = t_sample'($urandom_range(0, 16) - 8);
                    im = t_sample'($urandom_range(0, 16) - 8);
                end
                6: begin
                    re = t_sample'($urandom);
                    im = '0;
                    if ($urandom_range(0, 1)) begin
                        im = re;
                        re = '0;
                    end
                end
                7: begin
                    re = t_sample'(pick_extreme());
                    im = t_sample'(pick_extreme());
                end
                8: begin
                    a  = $urandom_range(0, 65535) - 32768;
                    re = t_sample'(a);
                    im = t_sample'(a + $urandom_range(0, 4) - 2);
                    if ($urandom_range(0, 1))
                        im = -im;
                end
                9: begin
                    re = t_sample'($urandom);
                    im = t_sample'(32767 - $urandom_range(0, 15));
                    if ($urandom_range(0, 1))
                        im = ~im;
                end
                default: begin
                    re = t_sample'($urandom);
                    im = t_sample'($urandom);
                end
            endcase
            send_sample(re, im, 1'b0, typed);
        end
        i_valid <= 1'b0;

        while (pending_polar.size() != 0)
            @(negedge i_clk);
        repeat (rtp_pkg::NUM_STAGES + 8) @(negedge i_clk);

        $display("%0d directed and %0d random samples sent, %0d results checked",
                 NUM_DIRECTED, NUM_RANDOM, transfers_out);
        $display("%0d samples on an axis, idle bursts on both channels until the last part",
                 axis_samples);
        if (error_count == 0)
            $display("rectangular_to_polar regression: pass");
        else
            $display("rectangular_to_polar regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("rectangular_to_polar regression: fail");
        $finish;
    end

endmodule

FILE: rectangular_to_polar.f
hdl/rtp_pkg.sv
hdl/rtp_prep.sv
hdl/rtp_cell.sv
hdl/rectangular_to_polar.sv
hdl/rtp_checker.sv
sim/tb.sv
